/* hdl/psvm_pkg.sv */
// Shared types, sizes and codes of the polyphonic sample voice mixer.
package psvm_pkg;

  // Sizing of the voice pool and the sample store.
  localparam int MAX_VOICES    = 16;
  localparam int SNIPPET_DEPTH = 1024;
  localparam int NOTE_COUNT    = 128;

  localparam int STORE_DEPTH = NOTE_COUNT * SNIPPET_DEPTH;
  localparam int STORE_AW    = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int NOTE_AW     = (NOTE_COUNT > 1) ? $clog2(NOTE_COUNT) : 1;
  localparam int VIDX_W      = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
  localparam int CNT_W       = $clog2(MAX_VOICES + 1);
  localparam int POS_W       = $clog2(SNIPPET_DEPTH + 1);

  // Field widths fixed by the item format.
  localparam int FUNC_W    = 2;
  localparam int NOTE_W    = 7;
  localparam int VEL_W     = 7;
  localparam int ADDR_W    = 10;
  localparam int SAMPLE_W  = 16;
  localparam int LEN_W     = 11;
  localparam int ACTIVE_W  = 5;
  localparam int ACTIVE_MAX = 31;

  // Mix arithmetic: product of sample and gain, summed over all voices.
  // The divisor is one less than a power of two so that the divide folds digits.
  localparam int PROD_W      = SAMPLE_W + VEL_W + 1;
  localparam int ACC_W       = PROD_W + CNT_W;
  localparam int MIX_SHIFT   = 7;
  localparam int MIX_DIVISOR = (1 << MIX_SHIFT) - 1;
  localparam int MIX_ROUND   = MIX_DIVISOR / 2;
  localparam int DIV_W       = ACC_W;
  localparam int MIX_POS_MAX = 32767;
  localparam int MIX_NEG_MAG = 32768;

  // Item function codes.
  typedef enum logic [FUNC_W-1:0] {
    FUNC_WRITE   = 2'd0,
    FUNC_LENGTH  = 2'd1,
    FUNC_NOTE_ON = 2'd2,
    FUNC_TICK    = 2'd3
  } func_t;

  typedef struct packed {
    func_t                      func;
    logic [NOTE_W-1:0]          note;
    logic [VEL_W-1:0]           velocity;
    logic [ADDR_W-1:0]          address;
    logic signed [SAMPLE_W-1:0] sample_word;
    logic [LEN_W-1:0]           snippet_length;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] mix_sample;
    logic [ACTIVE_W-1:0]        active_voices;
    logic                       note_dropped;
    logic                       clipped;
  } out_item_t;

endpackage

/* hdl/psvm_div127.sv */
// Divider of the mix magnitude by the fixed gain scale, folding base-128 digits per cycle.
module psvm_div127 (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [psvm_pkg::DIV_W-1:0]  dividend,
  output logic                        done,
  output logic [psvm_pkg::DIV_W-1:0]  quotient
);

  logic                         busy_r;
  logic                         done_r;
  logic [psvm_pkg::DIV_W-1:0]   quo_r;
  logic [psvm_pkg::DIV_W-1:0]   rem_r;
  logic [psvm_pkg::DIV_W-1:0]   rem_hi;
  logic [psvm_pkg::DIV_W-1:0]   rem_lo;
  logic                         rem_small;

  // Since 128 is one more than 127, each multiple of 128 left in the remainder moves
  // its count to the quotient and also adds that count back into the remainder.
  assign rem_hi    = rem_r >> psvm_pkg::MIX_SHIFT;
  assign rem_lo    = rem_r & psvm_pkg::DIV_W'(psvm_pkg::MIX_DIVISOR);
  assign rem_small = (rem_hi == '0);

  // The divide ends once the remainder is below 128; at most five folds are needed.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && rem_small) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // Datapath registers; a final remainder of exactly 127 is one more divisor.
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= '0;
      rem_r <= dividend;
    end else if (busy_r) begin
      if (!rem_small) begin
        quo_r <= quo_r + rem_hi;
        rem_r <= rem_lo + rem_hi;
      end else if (rem_r == psvm_pkg::DIV_W'(psvm_pkg::MIX_DIVISOR)) begin
        quo_r <= quo_r + 1'b1;
        rem_r <= '0;
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

/* hdl/polyphonic_sample_voice_mixer.sv */
// Top level of the polyphonic sample voice mixer: voice pool, stores and tick sequencer.
//
// Sample writes, length writes and note-ons leave the input free, so the block can
// take the next item right after them. A tick walks the voice slots one at a time
// through a single multiply-accumulate unit, each slot a registered read of the
// sample store and length table, then compare and accumulate, and then divides
// the rounded magnitude of the sum by 127 by folding base-128 digits back into
// the remainder, one fold per cycle and at most five folds. A tick stalls the
// input until its result enters the output register, and longer while an earlier
// result still waits at a stalled output.
// The finished result waits in an output register, so the block takes further
// items while it is stalled. The note length table is cleared at reset at once
// through per-note valid flags; there is no clearing pass.
module polyphonic_sample_voice_mixer (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  psvm_pkg::in_item_t   in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output psvm_pkg::out_item_t  out_item
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_MAC,
    S_START,
    S_DIV,
    S_OUT
  } state_t;

  // Sequencer and result registers.
  state_t                       state_r, state_nxt;
  logic [psvm_pkg::VIDX_W-1:0]  idx_r, idx_nxt;
  logic signed [psvm_pkg::ACC_W-1:0] acc_r, acc_nxt;
  logic [psvm_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                         drop_r, drop_nxt;
  logic                         out_valid_r, out_valid_nxt;
  psvm_pkg::out_item_t          out_item_r, out_item_nxt;

  // Voice pool.
  logic [psvm_pkg::MAX_VOICES-1:0] voice_vld_r;
  logic [psvm_pkg::NOTE_W-1:0]     voice_note_r [psvm_pkg::MAX_VOICES];
  logic [psvm_pkg::POS_W-1:0]      voice_pos_r  [psvm_pkg::MAX_VOICES];
  logic [psvm_pkg::VEL_W-1:0]      voice_gain_r [psvm_pkg::MAX_VOICES];

  // Sample store and note length table.
  logic [psvm_pkg::SAMPLE_W-1:0]   store_mem [psvm_pkg::STORE_DEPTH];
  logic [psvm_pkg::POS_W-1:0]      len_mem   [psvm_pkg::NOTE_COUNT];
  logic [psvm_pkg::NOTE_COUNT-1:0] len_vld_r;
  logic signed [psvm_pkg::SAMPLE_W-1:0] smp_rd_r;
  logic [psvm_pkg::POS_W-1:0]      len_rd_r;
  logic                            len_vld_rd_r;

  logic                            accept;
  logic                            note_ok;
  logic                            store_we;
  logic                            len_we;
  logic                            note_on;
  logic [psvm_pkg::STORE_AW-1:0]   store_waddr;
  logic [psvm_pkg::STORE_AW-1:0]   store_raddr;
  logic [psvm_pkg::NOTE_AW-1:0]    len_widx;
  logic [psvm_pkg::NOTE_AW-1:0]    len_ridx;
  logic [psvm_pkg::POS_W-1:0]      len_sat;
  logic                            free_found;
  logic [psvm_pkg::VIDX_W-1:0]     free_idx;
  logic [psvm_pkg::NOTE_W-1:0]     cur_note;
  logic [psvm_pkg::POS_W-1:0]      cur_pos;
  logic [psvm_pkg::POS_W-1:0]      eff_len;
  logic                            retire;
  logic                            mac_active;
  logic signed [psvm_pkg::PROD_W-1:0] prod;
  logic                            last_voice;
  logic                            acc_neg;
  logic [psvm_pkg::ACC_W-1:0]      acc_mag;
  logic                            div_start;
  logic                            div_done;
  logic [psvm_pkg::DIV_W-1:0]      div_dividend;
  logic [psvm_pkg::DIV_W-1:0]      div_quo;
  logic                            out_free;
  logic                            sat_clip;
  logic signed [psvm_pkg::SAMPLE_W-1:0] sat_mix;

  // Input handshake: items are taken only while the sequencer is idle.
  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign note_ok  = (32'(in_item.note) < psvm_pkg::NOTE_COUNT);

  assign store_we = accept && (in_item.func == psvm_pkg::FUNC_WRITE) && note_ok &&
                    (32'(in_item.address) < psvm_pkg::SNIPPET_DEPTH);
  assign len_we   = accept && (in_item.func == psvm_pkg::FUNC_LENGTH) && note_ok;
  assign note_on  = accept && (in_item.func == psvm_pkg::FUNC_NOTE_ON) && note_ok &&
                    (in_item.velocity != '0);

  assign store_waddr = psvm_pkg::STORE_AW'(32'(in_item.note) * psvm_pkg::SNIPPET_DEPTH +
                                           32'(in_item.address));
  assign len_widx    = psvm_pkg::NOTE_AW'(in_item.note);
  assign len_sat     = (32'(in_item.snippet_length) > psvm_pkg::SNIPPET_DEPTH) ?
                       psvm_pkg::POS_W'(psvm_pkg::SNIPPET_DEPTH) :
                       psvm_pkg::POS_W'(in_item.snippet_length);

  // Lowest-numbered free voice slot.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = psvm_pkg::MAX_VOICES - 1; i >= 0; i--) begin
      if (!voice_vld_r[i]) begin
        free_found = 1'b1;
        free_idx   = psvm_pkg::VIDX_W'(i);
      end
    end
  end

  // Current voice slot of the tick walk.
  assign cur_note    = voice_note_r[idx_r];
  assign cur_pos     = voice_pos_r[idx_r];
  assign store_raddr = psvm_pkg::STORE_AW'(32'(cur_note) * psvm_pkg::SNIPPET_DEPTH +
                                           32'(cur_pos));
  assign len_ridx    = psvm_pkg::NOTE_AW'(cur_note);

  // Store and table ports: one write at item accept, one registered read per slot.
  always_ff @(posedge clk) begin
    if (store_we) begin
      store_mem[store_waddr] <= in_item.sample_word;
    end
    if (len_we) begin
      len_mem[len_widx] <= len_sat;
    end
    if (state_r == S_READ) begin
      smp_rd_r     <= store_mem[store_raddr];
      len_rd_r     <= len_mem[len_ridx];
      len_vld_rd_r <= len_vld_r[len_ridx];
    end
  end

  // A note without a written length plays for zero samples.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_vld_r <= '0;
    end else if (len_we) begin
      len_vld_r[len_widx] <= 1'b1;
    end
  end

  // Retire check and the shared multiply-accumulate.
  assign eff_len    = len_vld_rd_r ? len_rd_r : '0;
  assign retire     = (32'(cur_pos) >= 32'(eff_len)) ||
                      (32'(cur_pos) >= psvm_pkg::SNIPPET_DEPTH) ||
                      (32'(cur_note) >= psvm_pkg::NOTE_COUNT);
  assign mac_active = (state_r == S_MAC) && voice_vld_r[idx_r];
  assign prod       = smp_rd_r * $signed({1'b0, voice_gain_r[idx_r]});
  assign last_voice = (32'(idx_r) == psvm_pkg::MAX_VOICES - 1);

  // Voice pool updates: note-on claims a slot, the tick walk advances or retires.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      voice_vld_r <= '0;
    end else begin
      if (note_on && free_found) begin
        voice_vld_r[free_idx] <= 1'b1;
      end
      if (mac_active && retire) begin
        voice_vld_r[idx_r] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (note_on && free_found) begin
      voice_note_r[free_idx] <= in_item.note;
      voice_gain_r[free_idx] <= in_item.velocity;
      voice_pos_r[free_idx]  <= '0;
    end
    if (mac_active && !retire) begin
      voice_pos_r[idx_r] <= cur_pos + 1'b1;
    end
  end

  // Rounded divide: magnitude plus half the divisor, sign restored afterward.
  assign acc_neg      = acc_r[psvm_pkg::ACC_W-1];
  assign acc_mag      = acc_neg ? psvm_pkg::ACC_W'(-acc_r) : psvm_pkg::ACC_W'(acc_r);
  assign div_dividend = psvm_pkg::DIV_W'(acc_mag) + psvm_pkg::DIV_W'(psvm_pkg::MIX_ROUND);
  assign div_start    = (state_r == S_START);

  psvm_div127 u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Saturation to the 16-bit output range.
  always_comb begin
    if (acc_neg) begin
      sat_clip = (div_quo > psvm_pkg::DIV_W'(psvm_pkg::MIX_NEG_MAG));
      sat_mix  = sat_clip ? -psvm_pkg::SAMPLE_W'(psvm_pkg::MIX_NEG_MAG) :
                            -$signed(div_quo[psvm_pkg::SAMPLE_W-1:0]);
    end else begin
      sat_clip = (div_quo > psvm_pkg::DIV_W'(psvm_pkg::MIX_POS_MAX));
      sat_mix  = sat_clip ? psvm_pkg::SAMPLE_W'(psvm_pkg::MIX_POS_MAX) :
                            $signed(div_quo[psvm_pkg::SAMPLE_W-1:0]);
    end
  end

  assign out_free = !out_valid_r || !out_stall;

  // Sequencer next state.
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    acc_nxt       = acc_r;
    cnt_nxt       = cnt_r;
    drop_nxt      = drop_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_item_nxt  = out_item_r;
    case (state_r)
      S_IDLE: begin
        if (note_on && !free_found) begin
          drop_nxt = 1'b1;
        end
        if (accept && (in_item.func == psvm_pkg::FUNC_TICK)) begin
          state_nxt = S_READ;
          idx_nxt   = '0;
          acc_nxt   = '0;
          cnt_nxt   = '0;
        end
      end
      S_READ: begin
        state_nxt = S_MAC;
      end
      S_MAC: begin
        if (mac_active && !retire) begin
          acc_nxt = acc_r + psvm_pkg::ACC_W'(prod);
          cnt_nxt = cnt_r + 1'b1;
        end
        if (last_voice) begin
          state_nxt = S_START;
        end else begin
          state_nxt = S_READ;
          idx_nxt   = idx_r + 1'b1;
        end
      end
      S_START: begin
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_nxt              = 1'b1;
          out_item_nxt.mix_sample    = sat_mix;
          out_item_nxt.active_voices = (32'(cnt_r) > psvm_pkg::ACTIVE_MAX) ?
                                       psvm_pkg::ACTIVE_W'(psvm_pkg::ACTIVE_MAX) :
                                       psvm_pkg::ACTIVE_W'(cnt_r);
          out_item_nxt.note_dropped  = drop_r;
          out_item_nxt.clipped       = sat_clip;
          drop_nxt                   = 1'b0;
          state_nxt                  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Sequencer state and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      cnt_r       <= '0;
      drop_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      cnt_r       <= cnt_nxt;
      drop_r      <= drop_nxt;
      out_valid_r <= out_valid_nxt;
    end
    acc_r      <= acc_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

/* hdl/psvm_checker.sv */
// Port-level checks of the voice mixer, bound to its top level.
module psvm_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input psvm_pkg::in_item_t  in_item,
  input logic                out_valid,
  input logic                out_stall,
  input psvm_pkg::out_item_t out_item
);

  // A tick keeps the block busy for at least the following cycle.
  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_item.func == psvm_pkg::FUNC_TICK) |=> in_stall)
    else $error("input taken right after a tick item");

  // A stalled result item holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result item changed");

  // The voice count never exceeds the pool.
  a_voice_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_item.active_voices) <= psvm_pkg::MAX_VOICES))
    else $error("active voice count above pool size");

  // A clipped mix sits at one of the range limits.
  a_clip_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.clipped |->
      (out_item.mix_sample == 16'sh7fff) || (out_item.mix_sample == 16'sh8000))
    else $error("clipped mix not at a range limit");

  // Other items than ticks produce no result while the output is empty.
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid && in_valid && !in_stall && (in_item.func != psvm_pkg::FUNC_TICK)
      |=> !out_valid)
    else $error("result item without a tick");

endmodule

bind polyphonic_sample_voice_mixer psvm_checker u_psvm_checker (.*);
